>>> rtl/etc_pkg.sv
// Shared types and constants for the encoder edge timestamp capture block.
package etc_pkg;

   localparam int TS_W    = 32;
   localparam int OVF_W   = 32;
   localparam int EDGE_W  = 16;
   localparam int SLOT_W  = 10;
   localparam int CSR_W   = 32;
   localparam int INDEX_W = 1;

   localparam logic [INDEX_W-1:0] CSR_WRAP_THRESHOLD = 1'b0;
   localparam logic [INDEX_W-1:0] CSR_PACKET_LENGTH  = 1'b1;

   localparam logic [TS_W-1:0]   RESET_WRAP_THRESHOLD = 32'h5FFF_FFFF;
   localparam logic [SLOT_W-1:0] RESET_PACKET_LENGTH  = 10'd150;

   typedef struct packed {
      logic              buffer_id;
      logic [SLOT_W-1:0] slot;
      logic [TS_W-1:0]   time_stamp;
      logic [OVF_W-1:0]  overflow_total;
      logic [EDGE_W-1:0] edge_total;
      logic              quad_capture;
      logic              quad_valid;
      logic              packet_done;
   } record_type;

   typedef struct packed {
      logic              previous_level;
      logic [EDGE_W-1:0] edge_counter;
      logic [SLOT_W-1:0] slot_counter;
      logic              active_buffer;
      logic              quad_pending;
   } state_type;

   localparam state_type STATE_RESET = '{
      previous_level: 1'b0,
      edge_counter:   '0,
      slot_counter:   '0,
      active_buffer:  1'b0,
      quad_pending:   1'b1
   };

endpackage

>>> rtl/etc_record.sv
// Edge detection, record formation and next tracking state for one sample.
module etc_record import etc_pkg::*; (
   input  state_type          state,
   input  logic [TS_W-1:0]    wrap_threshold,
   input  logic [SLOT_W-1:0]  packet_length,
   input  logic               encoder_level,
   input  logic               quad_level,
   input  logic [TS_W-1:0]    timer_count,
   input  logic               timer_wrapped,
   input  logic [OVF_W-1:0]   overflow_count,
   output logic               is_edge,
   output record_type         rec,
   output state_type          state_next
);

   logic              capture;
   logic              last_slot;
   logic [SLOT_W:0]   slot_plus;
   logic              wrap_fix;

   always_comb begin
      is_edge   = (encoder_level != state.previous_level);
      capture   = encoder_level && state.quad_pending;
      slot_plus = {1'b0, state.slot_counter} + {{SLOT_W{1'b0}}, 1'b1};
      // A zero length also ends the packet on every record.
      last_slot = (slot_plus >= {1'b0, packet_length});
      wrap_fix  = timer_wrapped && (timer_count < wrap_threshold);

      rec.buffer_id      = state.active_buffer;
      rec.slot           = state.slot_counter;
      rec.time_stamp     = timer_count;
      rec.overflow_total = overflow_count + {{(OVF_W-1){1'b0}}, wrap_fix};
      rec.edge_total     = state.edge_counter + {{(EDGE_W-1){1'b0}}, 1'b1};
      rec.quad_capture   = capture ? quad_level : 1'b0;
      rec.quad_valid     = capture;
      rec.packet_done    = last_slot;

      state_next = state;
      if (is_edge) begin
         state_next.previous_level = encoder_level;
         state_next.edge_counter   = rec.edge_total;
         if (capture) begin
            state_next.quad_pending = 1'b0;
         end
         if (last_slot) begin
            state_next.slot_counter  = '0;
            state_next.active_buffer = ~state.active_buffer;
            state_next.quad_pending  = 1'b1;
         end else begin
            state_next.slot_counter = slot_plus[SLOT_W-1:0];
         end
      end
   end

endmodule

>>> rtl/encoder_edge_timestamp_capture.sv
// Top level of the encoder edge timestamp capture block.
// Every accepted request is one sample of the encoder and quadrature pins together with
// the timer count, the timer wrap flag and the overflow count. Any change of the encoder
// level produces one record on the response channel; samples without an edge produce
// nothing. One request is taken every clock cycle: the tracking state (previous level,
// edge count, slot, buffer, quadrature arm) updates in the cycle of acceptance, and a
// response register with a one-entry skid stage holds results while the response side
// stalls, so a request is refused only when both are full. The two configuration
// registers should be written while no records are outstanding.
module encoder_edge_timestamp_capture import etc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_encoder_level,
   input  logic               req_quad_level,
   input  logic [TS_W-1:0]    req_timer_count,
   input  logic               req_timer_wrapped,
   input  logic [OVF_W-1:0]   req_overflow_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_buffer_id,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [TS_W-1:0]    rsp_time_stamp,
   output logic [OVF_W-1:0]   rsp_overflow_total,
   output logic [EDGE_W-1:0]  rsp_edge_total,
   output logic               rsp_quad_capture,
   output logic               rsp_quad_valid,
   output logic               rsp_packet_done
);

   logic [TS_W-1:0]   wrap_threshold_ff;
   logic [SLOT_W-1:0] packet_length_ff;
   state_type         state_ff;
   state_type         state_in;
   record_type        rec;
   logic              is_edge;
   logic              req_fire;
   logic              push;

   record_type        out_ff;
   record_type        out_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   record_type        skid_ff;
   record_type        skid_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;

   etc_record u_record (
      .state          (state_ff),
      .wrap_threshold (wrap_threshold_ff),
      .packet_length  (packet_length_ff),
      .encoder_level  (req_encoder_level),
      .quad_level     (req_quad_level),
      .timer_count    (req_timer_count),
      .timer_wrapped  (req_timer_wrapped),
      .overflow_count (req_overflow_count),
      .is_edge        (is_edge),
      .rec            (rec),
      .state_next     (state_in)
   );

   assign req_ready = ~skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign push      = req_fire && is_edge;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_threshold_ff <= RESET_WRAP_THRESHOLD;
         packet_length_ff  <= RESET_PACKET_LENGTH;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WRAP_THRESHOLD: wrap_threshold_ff <= csr_wdata[TS_W-1:0];
            CSR_PACKET_LENGTH:  packet_length_ff  <= csr_wdata[SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // The skid entry only fills when the response register is stalled, and it drains
   // into the response register before any new record can enter.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && !rsp_ready) begin
         if (push) begin
            skid_in       = rec;
            skid_valid_in = 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end else if (push) begin
         out_in       = rec;
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_buffer_id      = out_ff.buffer_id;
   assign rsp_slot           = out_ff.slot;
   assign rsp_time_stamp     = out_ff.time_stamp;
   assign rsp_overflow_total = out_ff.overflow_total;
   assign rsp_edge_total     = out_ff.edge_total;
   assign rsp_quad_capture   = out_ff.quad_capture;
   assign rsp_quad_valid     = out_ff.quad_valid;
   assign rsp_packet_done    = out_ff.packet_done;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a record while the response register is empty");

   a_edge_count: assert property (@(posedge clock) disable iff (reset)
      push |=> state_ff.edge_counter == $past(state_ff.edge_counter) + 16'd1)
      else $error("edge counter did not advance by one on an edge");

   a_packet_wrap: assert property (@(posedge clock) disable iff (reset)
      push && rec.packet_done |=> state_ff.slot_counter == '0 && state_ff.quad_pending)
      else $error("packet end did not restart slot and rearm quadrature capture");

   a_no_edge_no_record: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_edge |=> state_ff == $past(state_ff))
      else $error("tracking state changed on a request without an edge");

endmodule

>>> tb/tb_encoder_edge_timestamp_capture.sv
// Self-checking testbench for the encoder edge timestamp capture block.
module tb_encoder_edge_timestamp_capture;
   import etc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic             encoder_level;
      logic             quad_level;
      logic [TS_W-1:0]  timer_count;
      logic             timer_wrapped;
      logic [OVF_W-1:0] overflow_count;
   } sample_type;

   // Tracks the capture state and the records each accepted sample should produce.
   class capture_tracker;
      logic [TS_W-1:0]   wrap_threshold;
      logic [SLOT_W-1:0] packet_length;
      state_type         track;
      record_type        records_due[$];
      int                mismatches;

      function new();
         wrap_threshold = RESET_WRAP_THRESHOLD;
         packet_length  = RESET_PACKET_LENGTH;
         track          = STATE_RESET;
         mismatches     = 0;
      endfunction

      function void write_register(logic [INDEX_W-1:0] index, logic [CSR_W-1:0] value);
         case (index)
            CSR_WRAP_THRESHOLD: wrap_threshold = value[TS_W-1:0];
            CSR_PACKET_LENGTH:  packet_length  = value[SLOT_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_sample(sample_type s);
         record_type rec;
         logic       bump;
         if (s.encoder_level == track.previous_level)
            return;
         track.previous_level = s.encoder_level;
         track.edge_counter = track.edge_counter + 1'b1;
         rec = '0;
         rec.buffer_id  = track.active_buffer;
         rec.slot       = track.slot_counter;
         rec.time_stamp = s.timer_count;
         rec.edge_total = track.edge_counter;
         if (s.encoder_level && track.quad_pending) begin
            rec.quad_capture = s.quad_level;
            rec.quad_valid   = 1'b1;
            track.quad_pending = 1'b0;
         end
         bump = s.timer_wrapped && (s.timer_count < wrap_threshold);
         rec.overflow_total = s.overflow_count + {31'd0, bump};
         // A length of zero, or one below the current slot, closes the packet at once.
         if (int'(track.slot_counter) + 1 >= int'(packet_length)) begin
            rec.packet_done = 1'b1;
            track.slot_counter = '0;
            track.active_buffer = ~track.active_buffer;
            track.quad_pending = 1'b1;
         end else begin
            track.slot_counter = track.slot_counter + 1'b1;
         end
         records_due.push_back(rec);
      endfunction

      function void match_record(record_type got);
         record_type exp;
         string      bad;
         if (records_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("record with none outstanding: ts=%h edges=%0d",
                        got.time_stamp, got.edge_total);
            return;
         end
         exp = records_due.pop_front();
         bad = "";
         if (got.buffer_id !== exp.buffer_id)           bad = {bad, " buffer_id"};
         if (got.slot !== exp.slot)                     bad = {bad, " slot"};
         if (got.time_stamp !== exp.time_stamp)         bad = {bad, " time_stamp"};
         if (got.overflow_total !== exp.overflow_total) bad = {bad, " overflow_total"};
         if (got.edge_total !== exp.edge_total)         bad = {bad, " edge_total"};
         if (got.quad_capture !== exp.quad_capture)     bad = {bad, " quad_capture"};
         if (got.quad_valid !== exp.quad_valid)         bad = {bad, " quad_valid"};
         if (got.packet_done !== exp.packet_done)       bad = {bad, " packet_done"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("record mismatch in%s", bad);
               $display("  exp buf=%0d slot=%0d ts=%h ovf=%h edges=%0d q=%0d qv=%0d done=%0d",
                        exp.buffer_id, exp.slot, exp.time_stamp, exp.overflow_total,
                        exp.edge_total, exp.quad_capture, exp.quad_valid, exp.packet_done);
               $display("  got buf=%0d slot=%0d ts=%h ovf=%h edges=%0d q=%0d qv=%0d done=%0d",
                        got.buffer_id, got.slot, got.time_stamp, got.overflow_total,
                        got.edge_total, got.quad_capture, got.quad_valid, got.packet_done);
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_write;
   logic [INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]   csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic               req_encoder_level;
   logic               req_quad_level;
   logic [TS_W-1:0]    req_timer_count;
   logic               req_timer_wrapped;
   logic [OVF_W-1:0]   req_overflow_count;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_buffer_id;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [TS_W-1:0]    rsp_time_stamp;
   logic [OVF_W-1:0]   rsp_overflow_total;
   logic [EDGE_W-1:0]  rsp_edge_total;
   logic               rsp_quad_capture;
   logic               rsp_quad_valid;
   logic               rsp_packet_done;

   capture_tracker board;
   int             send_idle_pct;
   int             recv_stall_pct;
   bit             hold_off_request;

   encoder_edge_timestamp_capture dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_encoder_level  (req_encoder_level),
      .req_quad_level     (req_quad_level),
      .req_timer_count    (req_timer_count),
      .req_timer_wrapped  (req_timer_wrapped),
      .req_overflow_count (req_overflow_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_buffer_id      (rsp_buffer_id),
      .rsp_slot           (rsp_slot),
      .rsp_time_stamp     (rsp_time_stamp),
      .rsp_overflow_total (rsp_overflow_total),
      .rsp_edge_total     (rsp_edge_total),
      .rsp_quad_capture   (rsp_quad_capture),
      .rsp_quad_valid     (rsp_quad_valid),
      .rsp_packet_done    (rsp_packet_done)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Response side: checks every accepted record and stalls at random.
   initial begin : response_side
      int         hold_left;
      record_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = '{buffer_id: rsp_buffer_id, slot: rsp_slot, time_stamp: rsp_time_stamp,
                    overflow_total: rsp_overflow_total, edge_total: rsp_edge_total,
                    quad_capture: rsp_quad_capture, quad_valid: rsp_quad_valid,
                    packet_done: rsp_packet_done};
            board.match_record(got);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic sample_type make_sample(logic level, logic quad, logic [TS_W-1:0] ts,
                                              logic wrapped, logic [OVF_W-1:0] ovf);
      sample_type s;
      s = '{encoder_level: level, quad_level: quad, timer_count: ts,
            timer_wrapped: wrapped, overflow_count: ovf};
      return s;
   endfunction

   function automatic sample_type random_sample(bit toggle);
      sample_type s;
      s.encoder_level = toggle ? ~board.track.previous_level : board.track.previous_level;
      s.quad_level    = 1'($urandom_range(1));
      s.timer_wrapped = 1'($urandom_range(1));
      case ($urandom_range(5))
         0:       s.timer_count = '0;
         1:       s.timer_count = '1;
         2:       s.timer_count = board.wrap_threshold - 1'b1;
         3:       s.timer_count = board.wrap_threshold;
         default: s.timer_count = $urandom;
      endcase
      case ($urandom_range(3))
         0:       s.overflow_count = '1;
         1:       s.overflow_count = '0;
         default: s.overflow_count = $urandom;
      endcase
      return s;
   endfunction

   task automatic send_sample(input sample_type s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_encoder_level  <= s.encoder_level;
      req_quad_level     <= s.quad_level;
      req_timer_count    <= s.timer_count;
      req_timer_wrapped  <= s.timer_wrapped;
      req_overflow_count <= s.overflow_count;
      do @(posedge clock); while (!req_ready);
      board.take_sample(s);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.records_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers are written on back-to-back cycles with the write enable held high.
   task automatic program_registers(input logic [CSR_W-1:0] threshold,
                                    input logic [CSR_W-1:0] length_word);
      csr_write <= 1'b1;
      csr_index <= CSR_WRAP_THRESHOLD;
      csr_wdata <= threshold;
      @(posedge clock);
      board.write_register(CSR_WRAP_THRESHOLD, threshold);
      csr_index <= CSR_PACKET_LENGTH;
      csr_wdata <= length_word;
      @(posedge clock);
      board.write_register(CSR_PACKET_LENGTH, length_word);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] threshold, input logic [CSR_W-1:0] length_word,
                            input int idle_pct, input int stall_pct, input int edges);
      int made;
      bit toggle;
      made = 0;
      program_registers(threshold, length_word);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (made < edges) begin
         toggle = ($urandom_range(99) < 65);
         send_sample(random_sample(toggle));
         if (toggle)
            made++;
      end
      wait_drained();
   endtask

   initial begin
      board = new();
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      hold_off_request   = 1'b0;
      reset              <= 1'b1;
      csr_write          <= 1'b0;
      csr_index          <= CSR_WRAP_THRESHOLD;
      csr_wdata          <= '0;
      req_valid          <= 1'b0;
      req_encoder_level  <= 1'b0;
      req_quad_level     <= 1'b0;
      req_timer_count    <= '0;
      req_timer_wrapped  <= 1'b0;
      req_overflow_count <= '0;
      rsp_ready          <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings: first capture, overflow wrap,
      // the threshold boundary and samples without an edge.
      send_sample(make_sample(1'b0, 1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000));
      send_sample(make_sample(1'b1, 1'b1, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
      send_sample(make_sample(1'b1, 1'b0, 32'h1234_5678, 1'b1, 32'h0000_0001));
      send_sample(make_sample(1'b0, 1'b1, 32'h5FFF_FFFE, 1'b1, 32'h0000_0005));
      send_sample(make_sample(1'b1, 1'b1, 32'h5FFF_FFFF, 1'b1, 32'h0000_0007));
      send_sample(make_sample(1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF));
      wait_drained();

      // Length one, lowered below the current slot; a falling edge while the
      // capture is armed must leave it armed.
      program_registers(RESET_WRAP_THRESHOLD, 32'd1);
      send_sample(make_sample(1'b1, 1'b0, 32'h0000_007B, 1'b1, 32'h0000_0000));
      send_sample(make_sample(1'b0, 1'b1, 32'h8000_0000, 1'b1, 32'hAAAA_AAAA));
      send_sample(make_sample(1'b1, 1'b1, 32'h5555_5555, 1'b0, 32'h5555_5555));
      wait_drained();

      // A length of zero behaves as one.
      program_registers(RESET_WRAP_THRESHOLD, 32'd0);
      send_sample(make_sample(1'b0, 1'b1, 32'h0000_0001, 1'b1, 32'h0000_0010));
      send_sample(make_sample(1'b1, 1'b0, 32'h7FFF_FFFF, 1'b1, 32'h0000_0011));
      wait_drained();

      program_registers(32'h0000_0000, 32'd3);
      send_sample(make_sample(1'b0, 1'b1, 32'h0000_0000, 1'b1, 32'h0000_0020));
      send_sample(make_sample(1'b1, 1'b0, 32'h0000_0000, 1'b1, 32'h0000_0021));
      send_sample(make_sample(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0022));
      send_sample(make_sample(1'b1, 1'b1, 32'h0000_0001, 1'b1, 32'h0000_0023));
      wait_drained();

      program_registers(32'hFFFF_FFFF, 32'd2);
      send_sample(make_sample(1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
      send_sample(make_sample(1'b1, 1'b1, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF));
      send_sample(make_sample(1'b0, 1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000));
      send_sample(make_sample(1'b1, 1'b0, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000));
      wait_drained();

      // Random part: a long packet first so its last slot is reached, then a
      // short length that lands below the current slot.
      run_phase($urandom, 32'd600, 0, 0, 610);
      run_phase(32'h0000_0000, 32'd5, 71, 0, 30);
      run_phase(32'hFFFF_FFFF, {22'($urandom_range(22'h3F_FFFF)), 10'd0}, 0, 71, 30);
      run_phase($urandom, 32'($urandom_range(40, 1)), 24, 24, 30);
      run_phase(RESET_WRAP_THRESHOLD, {22'($urandom_range(22'h3F_FFFF)),
                10'($urandom_range(8, 2))}, 71, 0, 30);
      run_phase($urandom, 32'd150, 0, 71, 30);

      // The response side holds off long enough for the block to refuse requests.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_request = 1'b1;
      repeat (60) send_sample(random_sample(1'b1));
      wait_drained();

      repeat (8) @(posedge clock);
      if (board.records_due.size() != 0)
         board.mismatches++;
      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
